[hdl/eyt_pkg.sv]
package eyt_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int ANG_W        = 16;
    localparam int SC_W         = 24;
    localparam int SH_W         = 32;
    localparam int EL_W         = 32;
    localparam int N_LANES      = 3;
    localparam int N_ROT        = 9;
    localparam int CORDIC_ITERS = 24;
    localparam int CX_W         = 34;
    localparam int TRIG_W       = 32;
    localparam int MUL_W        = 33;
    localparam int R_W          = 34;
    localparam int CNT_W        = 3;

    localparam logic [CNT_W-1:0] CNT_TRANS = 3'd3;
    localparam logic [CNT_W-1:0] CNT_NORM0 = 3'd4;
    localparam logic [CNT_W-1:0] CNT_LAST  = 3'd6;

    localparam logic MATRIX_MODEL  = 1'b0;
    localparam logic MATRIX_NORMAL = 1'b1;

    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CX_W-1:0] ONE_Q30     = 34'sd1073741824;

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [MUL_W-1:0]  t_mul;
    typedef logic signed [R_W-1:0]    t_rot;

    typedef struct packed {
        logic signed [SH_W-1:0] sh_z;
        logic signed [SH_W-1:0] sh_y;
        logic signed [SH_W-1:0] sh_x;
        logic signed [SC_W-1:0] sc_z;
        logic signed [SC_W-1:0] sc_y;
        logic signed [SC_W-1:0] sc_x;
    } t_side;

    localparam int SIDE_W_DEF = $bits(t_side);

    typedef struct packed {
        logic       which;
        logic [1:0] col;
        logic       trans;
        logic       zs;
        logic       last;
    } t_beat_ctl;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic signed [CX_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CX_W-1:0] v;
        case (idx)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q2.30 product with rounding, floor shift.
    function automatic t_mul mul30(input t_mul a, input t_mul b);
        logic signed [2*MUL_W-1:0] p;
        p = a * b;
        p = p + (2*MUL_W)'(64'sd536870912);
        return p[MUL_W+29:30];
    endfunction

endpackage

[hdl/euler_yxz_transform_compose.sv]
// Composes an object transform from three Euler angles in YXZ order (yaw
// about Y, pitch about X, roll about Z), three signed scales and a
// translation. Each input beat yields seven output beats: the four columns
// of the 4x4 model matrix (scaled rotation columns, then the translation
// with a final one), then the three columns of the 3x3 normal matrix (the
// rotation columns divided by their scales, rounded half away from zero).
// All results are signed with FRAC_BITS fraction bits in 32 bits; normal
// entries saturate, and a zero scale saturates its normal column by the
// sign of each rotation entry and sets zero_scale on all seven beats of
// that transform. The datapath is fully pipelined: a 24-stage CORDIC per
// angle, three stages of rotation products, a column sequencer, and per
// column a scale multiplier beside a 32-stage restoring divider. The
// output channel carries one column per cycle while tready is high; the
// column sequencer takes a new transform as it issues the last column of
// the previous one. Holding tready low while an output beat waits freezes
// the whole pipeline without losing or repeating beats.
module euler_yxz_transform_compose import eyt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // angle_x [15:0], angle_y [31:16], angle_z [47:32], scale_x [71:48],
    // scale_y [95:72], scale_z [119:96], shift_x [151:120],
    // shift_y [183:152], shift_z [215:184]
    input  logic [215:0] i_s_axis_tdata,

    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // elem_0 [31:0], elem_1 [63:32], elem_2 [95:64], elem_3 [127:96]
    output logic [127:0] o_m_axis_tdata,
    // which_matrix [0], column_index [2:1], zero_scale [3]
    output logic [3:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);

    logic                   en;
    logic                   front_en;
    logic                   can_take;

    logic [ANG_W-1:0]       angles [N_LANES];
    t_side                  side_in;

    logic                   cor_v;
    t_trig                  cor_cos [N_LANES];
    t_trig                  cor_sin [N_LANES];
    logic [SIDE_W_DEF-1:0]  cor_side;

    logic                   rot_v;
    t_rot                   rot_r [N_ROT];
    logic [SIDE_W_DEF-1:0]  rot_side;

    logic                   col_v;
    t_beat_ctl              col_ctl;
    logic signed [EL_W-1:0] col_elem [4];

    // The whole pipeline advances whenever the output register is free or
    // being emptied. The front part also waits while the column sequencer
    // is still busy with the previous transform and a new one is ready.
    assign en       = !col_v || i_m_axis_tready;
    assign front_en = en && (!rot_v || can_take);

    assign o_s_axis_tready = front_en;

    // Lane order of the trigonometry: yaw, pitch, roll.
    assign angles[0] = i_s_axis_tdata[31:16];
    assign angles[1] = i_s_axis_tdata[15:0];
    assign angles[2] = i_s_axis_tdata[47:32];

    assign side_in.sc_x = i_s_axis_tdata[71:48];
    assign side_in.sc_y = i_s_axis_tdata[95:72];
    assign side_in.sc_z = i_s_axis_tdata[119:96];
    assign side_in.sh_x = i_s_axis_tdata[151:120];
    assign side_in.sh_y = i_s_axis_tdata[183:152];
    assign side_in.sh_z = i_s_axis_tdata[215:184];

    eyt_cordic #(
        .SIDE_W (SIDE_W_DEF)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (front_en),
        .i_valid (i_s_axis_tvalid),
        .i_angle (angles),
        .i_side  (side_in),
        .o_valid (cor_v),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin),
        .o_side  (cor_side)
    );

    eyt_rotation #(
        .SIDE_W (SIDE_W_DEF)
    ) u_rotation (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (front_en),
        .i_valid (cor_v),
        .i_cos   (cor_cos),
        .i_sin   (cor_sin),
        .i_side  (cor_side),
        .o_valid (rot_v),
        .o_r     (rot_r),
        .o_side  (rot_side)
    );

    eyt_column #(
        .FRAC_BITS (FRAC_BITS)
    ) u_column (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (rot_v),
        .i_r        (rot_r),
        .i_side     (t_side'(rot_side)),
        .o_can_take (can_take),
        .o_valid    (col_v),
        .o_ctl      (col_ctl),
        .o_elem     (col_elem)
    );

    assign o_m_axis_tvalid = col_v;
    assign o_m_axis_tdata  = {col_elem[3], col_elem[2], col_elem[1], col_elem[0]};
    assign o_m_axis_tuser  = {col_ctl.zs, col_ctl.col, col_ctl.which};
    assign o_m_axis_tlast  = col_ctl.last;

endmodule

[hdl/eyt_cordic.sv]
module eyt_cordic import eyt_pkg::*; #(
    parameter int SIDE_W = SIDE_W_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [ANG_W-1:0]  i_angle [N_LANES],
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_trig             o_cos [N_LANES],
    output t_trig             o_sin [N_LANES],
    output logic [SIDE_W-1:0] o_side
);

    localparam int N_ST = CORDIC_ITERS + 1;

    logic signed [CX_W-1:0] r_x [N_ST][N_LANES];
    logic signed [CX_W-1:0] r_y [N_ST][N_LANES];
    logic signed [CX_W-1:0] r_z [N_ST][N_LANES];
    logic                   r_flip [N_ST][N_LANES];
    logic                   r_v [N_ST+1];
    logic [SIDE_W-1:0]      r_side [N_ST+1];
    t_trig                  r_cos [N_LANES];
    t_trig                  r_sin [N_LANES];

    logic                   n_flip [N_LANES];
    logic signed [CX_W-1:0] n_z0 [N_LANES];

    function automatic t_trig finish(input logic signed [CX_W-1:0] v, input logic neg);
        logic signed [CX_W-1:0] c;
        if (v > ONE_Q30) begin
            c = ONE_Q30;
        end else if (v < -ONE_Q30) begin
            c = -ONE_Q30;
        end else begin
            c = v;
        end
        if (neg) begin
            c = -c;
        end
        return TRIG_W'(c);
    endfunction

    // Angles in the left half plane are turned by pi and the result negated.
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            n_flip[l] = i_angle[l][ANG_W-1] ^ i_angle[l][ANG_W-2];
            n_z0[l]   = CX_W'(signed'({i_angle[l][ANG_W-1] ^ n_flip[l],
                                       i_angle[l][ANG_W-2:0], 16'h0000}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int l = 0; l < N_LANES; l++) begin
                r_x[0][l]    <= CORDIC_GAIN;
                r_y[0][l]    <= '0;
                r_z[0][l]    <= n_z0[l];
                r_flip[0][l] <= n_flip[l];
            end
        end
    end

    for (genvar s = 1; s < N_ST; s++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= r_side[s-1];
                for (int l = 0; l < N_LANES; l++) begin
                    r_flip[s][l] <= r_flip[s-1][l];
                    if (!r_z[s-1][l][CX_W-1]) begin
                        r_x[s][l] <= r_x[s-1][l] - (r_y[s-1][l] >>> (s-1));
                        r_y[s][l] <= r_y[s-1][l] + (r_x[s-1][l] >>> (s-1));
                        r_z[s][l] <= r_z[s-1][l] - atan_q30(5'(s-1));
                    end else begin
                        r_x[s][l] <= r_x[s-1][l] + (r_y[s-1][l] >>> (s-1));
                        r_y[s][l] <= r_y[s-1][l] - (r_x[s-1][l] >>> (s-1));
                        r_z[s][l] <= r_z[s-1][l] + atan_q30(5'(s-1));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[N_ST] <= 1'b0;
        end else if (i_en) begin
            r_v[N_ST] <= r_v[N_ST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[N_ST] <= r_side[N_ST-1];
            for (int l = 0; l < N_LANES; l++) begin
                r_cos[l] <= finish(r_x[N_ST-1][l], r_flip[N_ST-1][l]);
                r_sin[l] <= finish(r_y[N_ST-1][l], r_flip[N_ST-1][l]);
            end
        end
    end

    assign o_valid = r_v[N_ST];
    assign o_side  = r_side[N_ST];
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

[hdl/eyt_rotation.sv]
module eyt_rotation import eyt_pkg::*; #(
    parameter int SIDE_W = SIDE_W_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_trig             i_cos [N_LANES],
    input  t_trig             i_sin [N_LANES],
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_rot              o_r [N_ROT],
    output logic [SIDE_W-1:0] o_side
);

    // Lane 0 carries yaw (c1, s1), lane 1 pitch (c2, s2), lane 2 roll (c3, s3).
    t_mul c1, s1, c2, s2, c3, s3;

    t_mul r_c1c3, r_s1s2, r_c1s2, r_c3s1, r_c1s3, r_c2s3, r_c2c3, r_s1s3, r_c2s1, r_c1c2;
    t_mul r_s2a, r_s3a;
    t_mul r_p_ss, r_p_cs, r_p_cs2, r_p_cc;
    t_mul r_c1c3b, r_c3s1b, r_c1s3b, r_c2s3b, r_c2c3b, r_s1s3b, r_c2s1b, r_c1c2b, r_s2b;
    t_rot r_r [N_ROT];
    logic r_v [3];
    logic [SIDE_W-1:0] r_side [3];

    assign c1 = MUL_W'(i_cos[0]);
    assign s1 = MUL_W'(i_sin[0]);
    assign c2 = MUL_W'(i_cos[1]);
    assign s2 = MUL_W'(i_sin[1]);
    assign c3 = MUL_W'(i_cos[2]);
    assign s3 = MUL_W'(i_sin[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
            r_v[2] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // First products.
            r_c1c3 <= mul30(c1, c3);
            r_s1s2 <= mul30(s1, s2);
            r_c1s2 <= mul30(c1, s2);
            r_c3s1 <= mul30(c3, s1);
            r_c1s3 <= mul30(c1, s3);
            r_c2s3 <= mul30(c2, s3);
            r_c2c3 <= mul30(c2, c3);
            r_s1s3 <= mul30(s1, s3);
            r_c2s1 <= mul30(c2, s1);
            r_c1c2 <= mul30(c1, c2);
            r_s2a  <= s2;
            r_s3a  <= s3;
            r_side[0] <= i_side;

            // Triple products.
            r_p_ss  <= mul30(r_s1s2, r_s3a);
            r_p_cs  <= mul30(r_c1s2, r_s3a);
            r_p_cs2 <= mul30(r_c3s1, r_s2a);
            r_p_cc  <= mul30(r_c1c3, r_s2a);
            r_c1c3b <= r_c1c3;
            r_c3s1b <= r_c3s1;
            r_c1s3b <= r_c1s3;
            r_c2s3b <= r_c2s3;
            r_c2c3b <= r_c2c3;
            r_s1s3b <= r_s1s3;
            r_c2s1b <= r_c2s1;
            r_c1c2b <= r_c1c2;
            r_s2b   <= r_s2a;
            r_side[1] <= r_side[0];

            // Matrix entries, column j row k at index 3j+k.
            r_r[0] <= R_W'(r_c1c3b) + R_W'(r_p_ss);
            r_r[1] <= R_W'(r_c2s3b);
            r_r[2] <= R_W'(r_p_cs) - R_W'(r_c3s1b);
            r_r[3] <= R_W'(r_p_cs2) - R_W'(r_c1s3b);
            r_r[4] <= R_W'(r_c2c3b);
            r_r[5] <= R_W'(r_p_cc) + R_W'(r_s1s3b);
            r_r[6] <= R_W'(r_c2s1b);
            r_r[7] <= -R_W'(r_s2b);
            r_r[8] <= R_W'(r_c1c2b);
            r_side[2] <= r_side[1];
        end
    end

    assign o_valid = r_v[2];
    assign o_r     = r_r;
    assign o_side  = r_side[2];

endmodule

[hdl/eyt_column.sv]
module eyt_column import eyt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_rot                   i_r [N_ROT],
    input  t_side                  i_side,
    output logic                   o_can_take,
    output logic                   o_valid,
    output t_beat_ctl              o_ctl,
    output logic signed [EL_W-1:0] o_elem [4]
);

    localparam int LSH       = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
    localparam int RSH       = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;
    localparam int NUM_W     = R_W + LSH;
    localparam int DEN_W     = SC_W + RSH;
    localparam int N_W       = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
    localparam int HI_W      = N_W - EL_W;
    localparam int CMP_W     = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int P_W       = SC_W + R_W;
    localparam int DIV_STEPS = EL_W;

    localparam logic signed [P_W-1:0]  RND30  = P_W'(1) << 29;
    localparam logic signed [EL_W-1:0] EL_MAX = {1'b0, {(EL_W-1){1'b1}}};
    localparam logic signed [EL_W-1:0] EL_MIN = {1'b1, {(EL_W-1){1'b0}}};
    localparam logic signed [EL_W-1:0] EL_ONE = EL_W'(1) << FRAC_BITS;

    // Issue sequencer.
    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    t_rot             r_item_r [N_ROT];
    t_side            r_item_side;
    logic             r_item_zs;

    logic                   n_norm;
    logic [1:0]             n_col;
    t_beat_ctl              n_ctl;
    logic signed [SC_W-1:0] n_sc;
    t_rot                   n_rsel [N_LANES];

    // Issue stage.
    logic                   r_a_v;
    t_beat_ctl              r_a_ctl;
    t_rot                   r_a_r [N_LANES];
    logic signed [SC_W-1:0] r_a_sc;
    logic signed [SH_W-1:0] r_a_sh [N_LANES];

    // Product and operand stage.
    logic                   sc_neg;
    logic [SC_W-1:0]        sc_mag;
    logic [DEN_W-1:0]       n_den;
    logic [R_W-1:0]         rot_mag [N_LANES];
    logic [N_W-1:0]         n_num [N_LANES];

    logic                   r_b_v;
    t_beat_ctl              r_b_ctl;
    logic signed [P_W-1:0]  r_b_prod [N_LANES];
    logic [N_W-1:0]         r_b_num [N_LANES];
    logic [DEN_W-1:0]       r_b_den;
    logic                   r_b_neg [N_LANES];
    logic                   r_b_rpos [N_LANES];
    logic                   r_b_rneg [N_LANES];
    logic                   r_b_zsc;
    logic signed [SH_W-1:0] r_b_sh [N_LANES];

    logic [CMP_W-1:0]       n_hi [N_LANES];
    logic signed [P_W-1:0]  n_sum [N_LANES];
    logic signed [EL_W-1:0] n_me [N_LANES];

    // Divider pipeline; index 0 holds the first remainder.
    logic                   r_d_v    [DIV_STEPS+1];
    t_beat_ctl              r_d_ctl  [DIV_STEPS+1];
    logic [DEN_W-1:0]       r_d_den  [DIV_STEPS+1];
    logic                   r_d_zsc  [DIV_STEPS+1];
    logic [DEN_W-1:0]       r_d_rem  [DIV_STEPS+1][N_LANES];
    logic [EL_W-1:0]        r_d_nl   [DIV_STEPS+1][N_LANES];
    logic [EL_W-1:0]        r_d_q    [DIV_STEPS+1][N_LANES];
    logic                   r_d_neg  [DIV_STEPS+1][N_LANES];
    logic                   r_d_rpos [DIV_STEPS+1][N_LANES];
    logic                   r_d_rneg [DIV_STEPS+1][N_LANES];
    logic                   r_d_ovf  [DIV_STEPS+1][N_LANES];
    logic signed [EL_W-1:0] r_d_me   [DIV_STEPS+1][N_LANES];

    // Output register.
    logic                   r_out_v;
    t_beat_ctl              r_out_ctl;
    logic signed [EL_W-1:0] r_out_e [4];
    logic signed [EL_W-1:0] n_ne [N_LANES];
    logic [EL_W-1:0]        n_qmag [N_LANES];

    assign o_can_take = !r_busy || (r_cnt == CNT_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_en) begin
            if (o_can_take) begin
                r_busy <= i_valid;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && o_can_take && i_valid) begin
            r_item_r    <= i_r;
            r_item_side <= i_side;
            r_item_zs   <= (i_side.sc_x == '0) || (i_side.sc_y == '0) || (i_side.sc_z == '0);
        end
    end

    always_comb begin
        n_norm = (r_cnt >= CNT_NORM0);
        n_col  = n_norm ? 2'(r_cnt - CNT_NORM0) : r_cnt[1:0];
        case (n_col)
            2'd0:    n_sc = r_item_side.sc_x;
            2'd1:    n_sc = r_item_side.sc_y;
            default: n_sc = r_item_side.sc_z;
        endcase
        for (int k = 0; k < N_LANES; k++) begin
            case (n_col)
                2'd0:    n_rsel[k] = r_item_r[k];
                2'd1:    n_rsel[k] = r_item_r[N_LANES + k];
                default: n_rsel[k] = r_item_r[2 * N_LANES + k];
            endcase
        end
        n_ctl.which = n_norm ? MATRIX_NORMAL : MATRIX_MODEL;
        n_ctl.col   = n_col;
        n_ctl.trans = (r_cnt == CNT_TRANS);
        n_ctl.zs    = r_item_zs;
        n_ctl.last  = (r_cnt == CNT_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= r_busy;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctl   <= n_ctl;
            r_a_r     <= n_rsel;
            r_a_sc    <= n_sc;
            r_a_sh[0] <= r_item_side.sh_x;
            r_a_sh[1] <= r_item_side.sh_y;
            r_a_sh[2] <= r_item_side.sh_z;
        end
    end

    // Magnitudes for the reciprocal path: the quotient is formed on
    // magnitudes with half the divisor added, so it rounds half away from zero.
    always_comb begin
        sc_neg = r_a_sc[SC_W-1];
        sc_mag = sc_neg ? SC_W'(-r_a_sc) : SC_W'(r_a_sc);
        n_den  = DEN_W'(sc_mag) << RSH;
        for (int l = 0; l < N_LANES; l++) begin
            rot_mag[l] = r_a_r[l][R_W-1] ? R_W'(-r_a_r[l]) : R_W'(r_a_r[l]);
            n_num[l]   = (N_W'(rot_mag[l]) << LSH) + N_W'(n_den >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_ctl <= r_a_ctl;
            r_b_den <= n_den;
            r_b_zsc <= (r_a_sc == '0);
            r_b_sh  <= r_a_sh;
            for (int l = 0; l < N_LANES; l++) begin
                r_b_prod[l] <= r_a_sc * r_a_r[l];
                r_b_num[l]  <= n_num[l];
                r_b_neg[l]  <= r_a_r[l][R_W-1] ^ sc_neg;
                r_b_rpos[l] <= !r_a_r[l][R_W-1] && (r_a_r[l] != '0);
                r_b_rneg[l] <= r_a_r[l][R_W-1];
            end
        end
    end

    // Scaled rotation entries never exceed 28 bits and shifts pass unchanged, so no saturation.
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            n_hi[l]  = CMP_W'(r_b_num[l][N_W-1:EL_W]);
            n_sum[l] = r_b_prod[l] + RND30;
            n_me[l]  = r_b_ctl.trans ? r_b_sh[l] : EL_W'(signed'(n_sum[l][P_W-1:30]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v[0] <= 1'b0;
        end else if (i_en) begin
            r_d_v[0] <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_ctl[0] <= r_b_ctl;
            r_d_den[0] <= r_b_den;
            r_d_zsc[0] <= r_b_zsc;
            for (int l = 0; l < N_LANES; l++) begin
                r_d_rem[0][l]  <= n_hi[l][DEN_W-1:0];
                r_d_nl[0][l]   <= r_b_num[l][EL_W-1:0];
                r_d_q[0][l]    <= '0;
                r_d_neg[0][l]  <= r_b_neg[l];
                r_d_rpos[0][l] <= r_b_rpos[l];
                r_d_rneg[0][l] <= r_b_rneg[l];
                r_d_ovf[0][l]  <= (n_hi[l] >= CMP_W'(r_b_den));
                r_d_me[0][l]   <= n_me[l];
            end
        end
    end

    // One restoring division step per stage, most significant bit first.
    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_div
        logic [DEN_W:0] w_trial [N_LANES];
        logic           w_ge    [N_LANES];

        always_comb begin
            for (int l = 0; l < N_LANES; l++) begin
                w_trial[l] = {r_d_rem[s-1][l], r_d_nl[s-1][l][EL_W-1]};
                w_ge[l]    = (w_trial[l] >= {1'b0, r_d_den[s-1]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_v[s] <= 1'b0;
            end else if (i_en) begin
                r_d_v[s] <= r_d_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d_ctl[s] <= r_d_ctl[s-1];
                r_d_den[s] <= r_d_den[s-1];
                r_d_zsc[s] <= r_d_zsc[s-1];
                for (int l = 0; l < N_LANES; l++) begin
                    r_d_rem[s][l]  <= w_ge[l] ? DEN_W'(w_trial[l] - {1'b0, r_d_den[s-1]})
                                              : w_trial[l][DEN_W-1:0];
                    r_d_nl[s][l]   <= {r_d_nl[s-1][l][EL_W-2:0], 1'b0};
                    r_d_q[s][l]    <= {r_d_q[s-1][l][EL_W-2:0], w_ge[l]};
                    r_d_neg[s][l]  <= r_d_neg[s-1][l];
                    r_d_rpos[s][l] <= r_d_rpos[s-1][l];
                    r_d_rneg[s][l] <= r_d_rneg[s-1][l];
                    r_d_ovf[s][l]  <= r_d_ovf[s-1][l];
                    r_d_me[s][l]   <= r_d_me[s-1][l];
                end
            end
        end
    end

    // Reciprocal entries: a zero scale gives the sign of the rotation entry
    // at full scale, a quotient of 2^31 or more saturates.
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            n_qmag[l] = {1'b0, r_d_q[DIV_STEPS][l][EL_W-2:0]};
            if (r_d_zsc[DIV_STEPS]) begin
                n_ne[l] = r_d_rpos[DIV_STEPS][l] ? EL_MAX :
                          (r_d_rneg[DIV_STEPS][l] ? EL_MIN : '0);
            end else if (r_d_ovf[DIV_STEPS][l] || r_d_q[DIV_STEPS][l][EL_W-1]) begin
                n_ne[l] = r_d_neg[DIV_STEPS][l] ? EL_MIN : EL_MAX;
            end else begin
                n_ne[l] = r_d_neg[DIV_STEPS][l] ? -signed'(n_qmag[l]) : signed'(n_qmag[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_d_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_ctl <= r_d_ctl[DIV_STEPS];
            for (int l = 0; l < N_LANES; l++) begin
                r_out_e[l] <= (r_d_ctl[DIV_STEPS].which == MATRIX_NORMAL) ? n_ne[l]
                                                                         : r_d_me[DIV_STEPS][l];
            end
            r_out_e[3] <= r_d_ctl[DIV_STEPS].trans ? EL_ONE : '0;
        end
    end

    assign o_valid = r_out_v;
    assign o_ctl   = r_out_ctl;
    assign o_elem  = r_out_e;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= CNT_LAST))
        else $error("issue counter beyond the last column");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_busy && (r_cnt != CNT_LAST)) |=>
            (r_busy && (r_cnt == CNT_W'($past(r_cnt) + 1'b1))))
        else $error("issue sequencer dropped or repeated a column");

    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_ctl.last) |->
            ((r_out_ctl.which == MATRIX_NORMAL) && (r_out_ctl.col == 2'd2)))
        else $error("last flag on a column other than the final normal column");

    a_row3_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_ctl.trans) |-> (r_out_e[3] == '0))
        else $error("row 3 non-zero outside the translation column");
`endif

endmodule

[verif/euler_yxz_transform_compose_test.sv]
`timescale 1ns / 100ps

// Self-checking bench for the Euler YXZ transform composer. Each transform beat
// sent in is predicted here as seven column beats (four model matrix columns,
// then three normal matrix columns); the monitor compares every output beat,
// field by field, with the oldest prediction still waiting.
module euler_yxz_transform_compose_test import eyt_pkg::*; ();

    localparam int FRAC = 16;
    localparam int NCOLS = 7;
    localparam longint LIMIT = 400000;

    // One input transform, kept in the order of the input fields.
    typedef struct {
        logic signed [15:0] ang[3];
        logic signed [23:0] sc[3];
        logic signed [31:0] sh[3];
    } t_xform;

    // One expected column beat.
    typedef struct {
        logic        which;
        logic [1:0]  col;
        logic [31:0] el[4];
        logic        zs;
        logic        last;
    } t_column;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, shift_x, shift_y, shift_z
    logic [215:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // elem_0, elem_1, elem_2, elem_3
    logic [127:0] o_m_axis_tdata;
    // which_matrix, column_index, zero_scale
    logic [3:0]   o_m_axis_tuser;
    logic         o_m_axis_tlast;

    t_xform  pending_xforms[$];
    t_column expected_columns[$];
    int      errors = 0;
    int      columns_seen = 0;
    int      xforms_sent = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_send = 0;
    longint  cycles = 0;

    euler_yxz_transform_compose #(.FRAC_BITS(FRAC)) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Floor shift right by 30 with rounding constant, as the hardware multiplies.
    function automatic longint mul_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // CORDIC sine and cosine of a 16-bit binary angle, Q2.30 results.
    task automatic angle_sincos(input logic [15:0] a, output longint c, output longint s);
        logic [31:0] z;
        bit          flip;
        longint      zi, x, y, nx, at;
        z    = {a, 16'd0};
        flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
        if (flip) z = z + 32'h8000_0000;
        zi = longint'($signed(z));
        x  = 652032874;
        y  = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            at = longint'(atan_q30(5'(i)));
            if (zi >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                zi = zi - at;
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                zi = zi + at;
            end
            x = nx;
        end
        if (x > (64'sd1 <<< 30)) x = 64'sd1 <<< 30;
        if (x < -(64'sd1 <<< 30)) x = -(64'sd1 <<< 30);
        if (y > (64'sd1 <<< 30)) y = 64'sd1 <<< 30;
        if (y < -(64'sd1 <<< 30)) y = -(64'sd1 <<< 30);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Normal matrix entry: rotation entry over scale, rounded half away from zero.
    function automatic longint inverse_scaled(longint r, longint sc);
        longint num, den, an, ad, q;
        bit     neg;
        if (sc == 0) return r > 0 ? 64'sd2147483647 : (r < 0 ? -64'sd2147483648 : 0);
        if (2 * FRAC >= 30) begin
            num = r * (64'sd1 <<< (2 * FRAC - 30));
            den = sc;
        end else begin
            num = r;
            den = sc * (64'sd1 <<< (30 - 2 * FRAC));
        end
        neg = (num < 0) != (den < 0);
        an  = num < 0 ? -num : num;
        ad  = den < 0 ? -den : den;
        q   = (an + ad / 2) / ad;
        if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
        return clip32(neg ? -q : q);
    endfunction

    // Works out the seven column beats of one transform.
    task automatic predict_columns(input t_xform t);
        longint  c1, s1, c2, s2, c3, s3;
        longint  rot[3][3];
        longint  sc;
        bit      zs;
        t_column col;
        angle_sincos(t.ang[1], c1, s1);
        angle_sincos(t.ang[0], c2, s2);
        angle_sincos(t.ang[2], c3, s3);
        zs = (t.sc[0] == 0) || (t.sc[1] == 0) || (t.sc[2] == 0);
        rot[0][0] = mul_q30(c1, c3) + mul_q30(mul_q30(s1, s2), s3);
        rot[0][1] = mul_q30(c2, s3);
        rot[0][2] = mul_q30(mul_q30(c1, s2), s3) - mul_q30(c3, s1);
        rot[1][0] = mul_q30(mul_q30(c3, s1), s2) - mul_q30(c1, s3);
        rot[1][1] = mul_q30(c2, c3);
        rot[1][2] = mul_q30(mul_q30(c1, c3), s2) + mul_q30(s1, s3);
        rot[2][0] = mul_q30(c2, s1);
        rot[2][1] = -s2;
        rot[2][2] = mul_q30(c1, c2);
        for (int j = 0; j < NCOLS; j++) begin
            col.which = (j >= 4) ? MATRIX_NORMAL : MATRIX_MODEL;
            col.col   = 2'(j >= 4 ? j - 4 : j);
            col.zs    = zs;
            col.last  = (j == 6);
            col.el[3] = '0;
            if (j == 3) begin
                for (int k = 0; k < 3; k++) col.el[k] = t.sh[k];
                col.el[3] = 32'(1) << FRAC;
            end else begin
                sc = longint'(t.sc[col.col]);
                for (int k = 0; k < 3; k++)
                    col.el[k] = (j < 3)
                        ? 32'(clip32((sc * rot[j][k] + (64'sd1 <<< 29)) >>> 30))
                        : 32'(inverse_scaled(rot[col.col][k], sc));
            end
            expected_columns.push_back(col);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH beat %0d %s: got %h expected %h", columns_seen, what, got, want);
    endtask

    // Driver: one transform beat at a time from the pending queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) begin
                predict_columns(pending_xforms.pop_front());
                xforms_sent++;
            end
            if (pending_xforms.size() != 0 && !hold_send &&
                $urandom_range(99, 0) >= send_idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {pending_xforms[0].sh[2], pending_xforms[0].sh[1],
                                    pending_xforms[0].sh[0], pending_xforms[0].sc[2],
                                    pending_xforms[0].sc[1], pending_xforms[0].sc[0],
                                    pending_xforms[0].ang[2], pending_xforms[0].ang[1],
                                    pending_xforms[0].ang[0]};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks every accepted output beat and varies the back-pressure.
    always @(posedge i_clk) begin
        t_column want;
        cycles++;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_columns.size() == 0) begin
                    report_mismatch("beat with nothing expected, elem_0",
                                    o_m_axis_tdata[31:0], '0);
                end else begin
                    want = expected_columns.pop_front();
                    if (o_m_axis_tuser[0] != want.which)
                        report_mismatch("which_matrix", o_m_axis_tuser[0], want.which);
                    if (o_m_axis_tuser[2:1] != want.col)
                        report_mismatch("column_index", o_m_axis_tuser[2:1], want.col);
                    if (o_m_axis_tuser[3] != want.zs)
                        report_mismatch("zero_scale", o_m_axis_tuser[3], want.zs);
                    if (o_m_axis_tlast != want.last)
                        report_mismatch("last", o_m_axis_tlast, want.last);
                    for (int k = 0; k < 4; k++)
                        if (o_m_axis_tdata[32*k +: 32] != want.el[k])
                            report_mismatch($sformatf("elem_%0d", k),
                                            o_m_axis_tdata[32*k +: 32], want.el[k]);
                end
                columns_seen++;
            end
            if (cycles > LIMIT) begin
                $display("Timed out after %0d cycles", cycles);
                $display("euler_yxz_transform_compose test failed");
                $finish;
            end
        end
    end

    function automatic t_xform random_xform();
        t_xform t;
        for (int k = 0; k < 3; k++) begin
            t.ang[k] = 16'($urandom);
            t.sh[k]  = 32'($urandom);
            // Mostly scales between minus two and two, with full-range, tiny and zero ones too.
            case ($urandom_range(9, 0))
                0:       t.sc[k] = 24'($urandom);
                1:       t.sc[k] = '0;
                2:       t.sc[k] = 24'($urandom_range(255, 0)) - 24'd128;
                default: t.sc[k] = 24'($urandom_range(32'h4_0000, 0)) - 24'h2_0000;
            endcase
        end
        return t;
    endfunction

    task automatic queue_phase(input int n, input int idle, input int stall);
        wait (pending_xforms.size() == 0);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) pending_xforms.push_back(random_xform());
    endtask

    initial begin
        t_xform t;
        logic signed [15:0] angles[8];
        angles = '{16'sh0000, 16'sh4000, -16'sh8000, 16'shC000,
                   16'sh7FFF, 16'sh3FFF, 16'sh8001, 16'sh2000};
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: quadrant edges of every angle, extreme scales and shifts,
        // zero scales on each axis, and negative scales.
        for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 3; k++) begin
                t.ang[k] = angles[(i + 3 * k) % 8];
                t.sc[k]  = 24'sh01_0000;
                t.sh[k]  = 32'sh0001_0000;
            end
            pending_xforms.push_back(t);
        end
        for (int i = 0; i < 12; i++) begin
            t = random_xform();
            case (i)
                0: t.sc = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
                1: t.sc = '{-24'sh800000, -24'sh800000, -24'sh800000};
                2: t.sc = '{24'sh000000, 24'sh010000, 24'sh010000};
                3: t.sc = '{24'sh010000, 24'sh000000, 24'sh010000};
                4: t.sc = '{24'sh010000, 24'sh010000, 24'sh000000};
                5: t.sc = '{24'sh000001, -24'sh000001, 24'sh000002};
                6: t.sc = '{-24'sh010000, -24'sh008000, 24'sh020000};
                7: t.sh = '{32'sh7FFFFFFF, -32'sh80000000, 32'sh0};
                8: t.sh = '{-32'sh80000000, 32'sh7FFFFFFF, -32'sh1};
                9: t.sc = '{24'sh000000, 24'sh000000, 24'sh000000};
                default: ;
            endcase
            pending_xforms.push_back(t);
        end

        // Random phases under each kind of idling.
        queue_phase(50, 0, 0);
        queue_phase(50, 59, 0);
        queue_phase(50, 0, 59);
        // Let the block drain completely before the last phase.
        wait (pending_xforms.size() == 0);
        hold_send = 1;
        wait (expected_columns.size() == 0 && !i_s_axis_tvalid);
        hold_send = 0;
        queue_phase(50, 12, 12);

        wait (pending_xforms.size() == 0 && !i_s_axis_tvalid && expected_columns.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d transforms and checked %0d column beats,", xforms_sent, columns_seen);
        $display("including zero, negative and full-range scales under varied stalls.");
        if (errors == 0) begin
            $display("euler_yxz_transform_compose test passed");
        end else begin
            $display("euler_yxz_transform_compose test failed");
        end
        $finish;
    end

endmodule
